// File: hw/rtl/hrla_pkg.sv
// ----------------------------------------------------------------------------
// hrla_pkg
// Shared widths, operation codes and bucket sizing for the reverse lookup unit.
// ----------------------------------------------------------------------------
package hrla_pkg;

	localparam int DEPTH       = 256;
	localparam int VALUE_WIDTH = 32;

	localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	// sizes and bucket starts need one bit more than an index
	localparam int SIZE_W  = IDX_W + 1;
	localparam int CFG_W   = 9;

	localparam int BUCKET_MAX = 283;
	localparam int BKT_W      = $clog2(BUCKET_MAX);

	localparam int MOD_DIGIT = 8;
	localparam int MOD_STEPS = (VALUE_WIDTH + MOD_DIGIT - 1) / MOD_DIGIT;
	localparam int MOD_W     = MOD_STEPS * MOD_DIGIT;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_FIND  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef struct packed {
		logic             start;
		logic [MOD_W-1:0] value;
		logic [BKT_W-1:0] divisor;
	} mod_req_t;

	typedef struct packed {
		logic             done;
		logic [BKT_W-1:0] remainder;
	} mod_rsp_t;

	// prime bucket count picked from the size in use
	function automatic logic [BKT_W-1:0] bucket_count(input logic [SIZE_W-1:0] size);
		logic [BKT_W-1:0] nb;
		if (int'(size) < 11)       nb = BKT_W'(11);
		else if (int'(size) < 19)  nb = BKT_W'(19);
		else if (int'(size) < 37)  nb = BKT_W'(37);
		else if (int'(size) < 67)  nb = BKT_W'(67);
		else if (int'(size) < 131) nb = BKT_W'(131);
		else                       nb = BKT_W'(BUCKET_MAX);
		return nb;
	endfunction

endpackage

// File: hw/rtl/hrla_ram.sv
// ----------------------------------------------------------------------------
// hrla_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hrla_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hw/rtl/hrla_mod_unit.sv
// ----------------------------------------------------------------------------
// hrla_mod_unit
// Value modulo a small divisor, one byte of the value per cycle, MSB first.
// ----------------------------------------------------------------------------
module hrla_mod_unit
	import hrla_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  mod_req_t req,
	output mod_rsp_t rsp
);

	localparam int CNT_W = $clog2(MOD_STEPS + 1);

	logic [MOD_W-1:0] sh_q;
	logic [BKT_W-1:0] rem_q;
	logic [BKT_W-1:0] div_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [BKT_W-1:0] rem_next;

	// remainder stays below the divisor, so 2r+1 fits in one extra bit
	always_comb begin
		logic [BKT_W:0] t;
		rem_next = rem_q;
		for (int k = 0; k < MOD_DIGIT; k++) begin
			t = {rem_next, sh_q[MOD_W-1-k]};
			if (t >= {1'b0, div_q}) begin
				t = t - {1'b0, div_q};
			end
			rem_next = t[BKT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sh_q   <= '0;
			rem_q  <= '0;
			div_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= !req.start && busy_q && (cnt_q == CNT_W'(1));
			if (req.start) begin
				sh_q   <= req.value;
				rem_q  <= '0;
				div_q  <= req.divisor;
				cnt_q  <= CNT_W'(MOD_STEPS);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= rem_next;
				sh_q  <= sh_q << MOD_DIGIT;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign rsp.done      = done_q;
	assign rsp.remainder = rem_q;

endmodule

// File: hw/rtl/hashed_reverse_lookup_array_unit.sv
// ----------------------------------------------------------------------------
// hashed_reverse_lookup_array_unit
// Indexed value store with a hashed reverse lookup (value to lowest index).
// ----------------------------------------------------------------------------
//  channel  | signals                                   | moves
//  ---------+-------------------------------------------+----------------------
//  cfg      | cfg_we, cfg_wdata                          | table_size, no wait
//  in       | in_valid/in_ready, operation, entry_index, | one op per beat
//           | entry_value                                |
//  out      | out_valid/out_ready, read_value,           | one result per beat
//           | found_index, found, status                 |
//
//  After an accepted beat: a write runs the byte-serial modulo, then a bucket RMW;
//  a find runs the modulo, reads its bucket start, then scans entries from there
//  through the value RAM port; a read reads the value RAM; a refused index goes
//  straight to the result. Clear, table_size write and reset: a pass over all 283
//  buckets sets every bucket start to empty; no op is taken meanwhile.
//  The result sits in an output register, so the next op is taken while it waits.
// ----------------------------------------------------------------------------
module hashed_reverse_lookup_array_unit
	import hrla_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_W-1:0]       cfg_wdata,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             operation,
	input  logic [IDX_W-1:0]       entry_index,
	input  logic [VALUE_WIDTH-1:0] entry_value,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [VALUE_WIDTH-1:0] read_value,
	output logic [IDX_W-1:0]       found_index,
	output logic                   found,
	output logic                   status
);

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_HASH,
		ST_BCHK,
		ST_VRD,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t                 state_q;
	logic [CFG_W-1:0]       table_size_q;
	logic [DEPTH-1:0]       valid_q;
	logic [BKT_W-1:0]       sweep_q;
	logic                   clr_q;
	op_t                    op_q;
	logic [IDX_W-1:0]       idx_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [SIZE_W-1:0]      scan_q;
	logic                   cmp_vld_s1;
	logic                   vbit_s1;
	logic [IDX_W-1:0]       cmp_idx_s1;

	logic [VALUE_WIDTH-1:0] res_rd_q;
	logic [IDX_W-1:0]       res_fidx_q;
	logic                   res_fnd_q;
	logic                   res_st_q;

	logic                   out_valid_q;
	logic [VALUE_WIDTH-1:0] out_rd_q;
	logic [IDX_W-1:0]       out_fidx_q;
	logic                   out_fnd_q;
	logic                   out_st_q;

	logic [SIZE_W-1:0]      size_in_use;
	logic                   accept;
	logic                   in_range;
	op_t                    op_in;
	logic                   hit;
	logic                   out_load;

	logic                   vram_we;
	logic [IDX_W-1:0]       vram_raddr;
	logic [VALUE_WIDTH-1:0] vram_rdata;
	logic                   bram_we;
	logic [BKT_W-1:0]       bram_waddr;
	logic [SIZE_W-1:0]      bram_wdata;
	logic [SIZE_W-1:0]      bram_rdata;

	mod_req_t               mod_req;
	mod_rsp_t               mod_rsp;

	assign size_in_use = (int'(table_size_q) > DEPTH) ? SIZE_W'(DEPTH)
	                                                  : SIZE_W'(table_size_q);
	assign op_in    = op_t'(operation);
	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign in_range = ({1'b0, entry_index} < size_in_use);
	assign out_load = !cfg_we && (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// value store
	assign vram_we    = accept && (op_in == OP_WRITE) && in_range;
	assign vram_raddr = (state_q == ST_SCAN) ? scan_q[IDX_W-1:0] : entry_index;

	hrla_ram #(
		.WIDTH (VALUE_WIDTH),
		.DEPTH (DEPTH)
	) u_value_ram (
		.clk   (clk),
		.we    (vram_we),
		.waddr (entry_index),
		.wdata (entry_value),
		.raddr (vram_raddr),
		.rdata (vram_rdata)
	);

	// bucket hash, started straight off the accepted beat
	assign mod_req.start   = accept && (((op_in == OP_WRITE) && in_range) || (op_in == OP_FIND));
	assign mod_req.value   = MOD_W'(entry_value);
	assign mod_req.divisor = bucket_count(size_in_use);

	hrla_mod_unit u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mod_req),
		.rsp    (mod_rsp)
	);

	// bucket starts: sweep fill or lower-on-write
	assign bram_we    = (state_q == ST_SWEEP) ||
	                    ((state_q == ST_BCHK) && (op_q == OP_WRITE) &&
	                     (bram_rdata > {1'b0, idx_q}));
	assign bram_waddr = (state_q == ST_SWEEP) ? sweep_q : mod_rsp.remainder;
	assign bram_wdata = (state_q == ST_SWEEP) ? '1 : {1'b0, idx_q};

	hrla_ram #(
		.WIDTH (SIZE_W),
		.DEPTH (BUCKET_MAX)
	) u_bucket_ram (
		.clk   (clk),
		.we    (bram_we),
		.waddr (bram_waddr),
		.wdata (bram_wdata),
		.raddr (mod_rsp.remainder),
		.rdata (bram_rdata)
	);

	assign hit = cmp_vld_s1 && vbit_s1 && (vram_rdata == val_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_SWEEP;
			table_size_q <= CFG_W'(256);
			valid_q      <= '0;
			sweep_q      <= '0;
			clr_q        <= 1'b0;
			op_q         <= OP_WRITE;
			idx_q        <= '0;
			val_q        <= '0;
			scan_q       <= '0;
			cmp_vld_s1   <= 1'b0;
			vbit_s1      <= 1'b0;
			cmp_idx_s1   <= '0;
			res_rd_q     <= '0;
			res_fidx_q   <= '0;
			res_fnd_q    <= 1'b0;
			res_st_q     <= 1'b0;
			out_valid_q  <= 1'b0;
			out_rd_q     <= '0;
			out_fidx_q   <= '0;
			out_fnd_q    <= 1'b0;
			out_st_q     <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				// new size: fresh, empty store
				table_size_q <= cfg_wdata;
				valid_q      <= '0;
				sweep_q      <= '0;
				clr_q        <= 1'b0;
				state_q      <= ST_SWEEP;
			end else begin
				unique case (state_q)
					ST_SWEEP: begin
						sweep_q <= sweep_q + 1'b1;
						if (sweep_q == BKT_W'(BUCKET_MAX - 1)) begin
							clr_q   <= 1'b0;
							state_q <= clr_q ? ST_DONE : ST_IDLE;
						end
					end
					ST_IDLE: begin
						if (accept) begin
							op_q       <= op_in;
							idx_q      <= entry_index;
							val_q      <= entry_value;
							res_rd_q   <= '0;
							res_fidx_q <= '0;
							res_fnd_q  <= 1'b0;
							res_st_q   <= 1'b0;
							unique case (op_in)
								OP_WRITE: begin
									if (in_range) begin
										valid_q[entry_index] <= 1'b1;
										state_q              <= ST_HASH;
									end else begin
										res_st_q <= 1'b1;
										state_q  <= ST_DONE;
									end
								end
								OP_READ: begin
									if (in_range) begin
										state_q <= ST_VRD;
									end else begin
										res_st_q <= 1'b1;
										state_q  <= ST_DONE;
									end
								end
								OP_FIND: state_q <= ST_HASH;
								OP_CLEAR: begin
									valid_q <= '0;
									sweep_q <= '0;
									clr_q   <= 1'b1;
									state_q <= ST_SWEEP;
								end
								default: state_q <= ST_IDLE;
							endcase
						end
					end
					ST_HASH: begin
						if (mod_rsp.done) begin
							state_q <= ST_BCHK;
						end
					end
					ST_BCHK: begin
						if (op_q == OP_FIND) begin
							scan_q     <= bram_rdata;
							cmp_vld_s1 <= 1'b0;
							state_q    <= ST_SCAN;
						end else begin
							state_q <= ST_DONE;
						end
					end
					ST_VRD: begin
						res_rd_q <= vram_rdata;
						state_q  <= ST_DONE;
					end
					ST_SCAN: begin
						// issue one address a cycle, compare the one issued last cycle
						if (hit) begin
							res_fnd_q  <= 1'b1;
							res_fidx_q <= cmp_idx_s1;
							cmp_vld_s1 <= 1'b0;
							state_q    <= ST_DONE;
						end else if (scan_q < size_in_use) begin
							cmp_vld_s1 <= 1'b1;
							vbit_s1    <= valid_q[scan_q[IDX_W-1:0]];
							cmp_idx_s1 <= scan_q[IDX_W-1:0];
							scan_q     <= scan_q + 1'b1;
						end else begin
							cmp_vld_s1 <= 1'b0;
							state_q    <= ST_DONE;
						end
					end
					ST_DONE: begin
						if (out_load) begin
							out_valid_q <= 1'b1;
							out_rd_q    <= res_rd_q;
							out_fidx_q  <= res_fidx_q;
							out_fnd_q   <= res_fnd_q;
							out_st_q    <= res_st_q;
							state_q     <= ST_IDLE;
						end
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign read_value  = out_rd_q;
	assign found_index = out_fidx_q;
	assign found       = out_fnd_q;
	assign status      = out_st_q;

endmodule

// File: hw/rtl/hrla_checker.sv
// ----------------------------------------------------------------------------
// hrla_checker
// Port-level checks for the reverse lookup unit, bound to the top level.
// ----------------------------------------------------------------------------
module hrla_checker
	import hrla_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   cfg_we,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [VALUE_WIDTH-1:0] read_value,
	input logic [IDX_W-1:0]       found_index,
	input logic                   found,
	input logic                   status
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_value) &&
		$stable(found_index) && $stable(found) && $stable(status))
		else $error("result beat changed while stalled");

	// a size write starts the bucket clearing pass
	a_cfg_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !in_ready)
		else $error("op taken right after a size write");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> !status && (read_value == '0))
		else $error("find hit with error status or read data");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> (found_index == '0))
		else $error("found_index set without a hit");

	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> (read_value == '0) && !found)
		else $error("refused op returned data");

endmodule

bind hashed_reverse_lookup_array_unit hrla_checker u_hrla_checker (.*);
